@@ src/mwmf_pkg.sv @@
// shared constants and types for the masked window median filter
// no dependencies
`default_nettype none

package mwmf_pkg;

  localparam int unsigned MAX_KERNEL_DEF  = 7;
  localparam int unsigned MAX_LINE_DEF    = 1024;
  localparam int unsigned SAMPLE_BITS_DEF = 16;

  localparam int unsigned MASK_STRIDE  = 7;
  localparam int unsigned MAX_ROWS     = 4096;
  localparam int unsigned ROW_W        = 12;
  localparam int unsigned LINE_LEN_W   = 11;
  localparam int unsigned FRAME_ROWS_W = 13;
  localparam int unsigned KDIM_W       = 3;
  localparam int unsigned MASK_W       = 49;
  localparam int unsigned MASK_IDX_W   = 6;
  localparam int unsigned CFG_IDX_W    = 3;

  localparam logic [LINE_LEN_W-1:0]   LINE_LEN_RST   = 11'd1024;
  localparam logic [FRAME_ROWS_W-1:0] FRAME_ROWS_RST = 13'd1024;
  localparam logic [KDIM_W-1:0]       KDIM_RST       = 3'd3;
  localparam logic [MASK_W-1:0]       MASK_RST       = 49'd115591;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LINE_LENGTH = 3'd0,
    CFG_FRAME_ROWS  = 3'd1,
    CFG_KERNEL_COLS = 3'd2,
    CFG_KERNEL_ROWS = 3'd3,
    CFG_KERNEL_MASK = 3'd4
  } cfg_idx_e;

  typedef struct packed {
    logic emit;
    logic last;
  } pix_ctrl_t;

endpackage

`default_nettype wire

@@ src/mwmf_col_store.sv @@
// column history memory: read-modify-write of the last kernel rows per column
// depends on mwmf_pkg
`default_nettype none

module mwmf_col_store
  import mwmf_pkg::*;
#(
  parameter int unsigned MAX_KERNEL  = MAX_KERNEL_DEF,
  parameter int unsigned MAX_LINE    = MAX_LINE_DEF,
  parameter int unsigned SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  wire logic                                      clk_i,
  input  wire logic                                      rst_ni,
  input  wire logic                                      en_i,
  input  wire logic                                      rd_i,
  input  wire logic [$clog2(MAX_LINE)-1:0]               rd_addr_i,
  input  wire logic [SAMPLE_BITS-1:0]                    sample_i,
  input  wire pix_ctrl_t                                 ctrl_i,
  output logic                                           col_valid_o,
  output logic [MAX_KERNEL-1:0][SAMPLE_BITS-1:0]         col_o,
  output pix_ctrl_t                                      ctrl_o
);

  localparam int unsigned CW   = $clog2(MAX_LINE);
  localparam int unsigned HIST = (MAX_KERNEL > 1) ? MAX_KERNEL - 1 : 1;

  logic [HIST-1:0][SAMPLE_BITS-1:0] mem [MAX_LINE];
  logic [HIST-1:0][SAMPLE_BITS-1:0] rdata_q, hit_data_q, hist, wword;
  logic                             hit_q;
  logic                             s1_v_q;
  logic [CW-1:0]                    s1_addr_q;
  logic [SAMPLE_BITS-1:0]           s1_sample_q;
  pix_ctrl_t                        s1_ctrl_q;
  logic [MAX_KERNEL-1:0][SAMPLE_BITS-1:0] colv;
  logic                             wr;

  assign wr   = en_i && s1_v_q;
  assign hist = hit_q ? hit_data_q : rdata_q;

  always_comb begin
    colv[0] = s1_sample_q;
    for (int a = 1; a < MAX_KERNEL; a++) begin
      colv[a] = hist[a-1];
    end
    for (int a = 0; a < HIST; a++) begin
      wword[a] = colv[a];
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr) begin
      mem[s1_addr_q] <= wword;
    end
    if (en_i && rd_i) begin
      rdata_q     <= mem[rd_addr_i];
      hit_q       <= wr && (s1_addr_q == rd_addr_i);
      hit_data_q  <= wword;
      s1_addr_q   <= rd_addr_i;
      s1_sample_q <= sample_i;
      s1_ctrl_q   <= ctrl_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
    end else if (en_i) begin
      s1_v_q <= rd_i;
    end
  end

  assign col_valid_o = s1_v_q;
  assign col_o       = colv;
  assign ctrl_o      = s1_ctrl_q;

endmodule

`default_nettype wire

@@ src/mwmf_window.sv @@
// window register array: shifts in one column per transfer
// depends on mwmf_pkg
`default_nettype none

module mwmf_window
  import mwmf_pkg::*;
#(
  parameter int unsigned MAX_KERNEL  = MAX_KERNEL_DEF,
  parameter int unsigned SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  wire logic                                              clk_i,
  input  wire logic                                              rst_ni,
  input  wire logic                                              en_i,
  input  wire logic                                              col_valid_i,
  input  wire logic [MAX_KERNEL-1:0][SAMPLE_BITS-1:0]            col_i,
  input  wire pix_ctrl_t                                         ctrl_i,
  output logic                                                   win_valid_o,
  output logic                                                   win_last_o,
  output logic [MAX_KERNEL-1:0][MAX_KERNEL-1:0][SAMPLE_BITS-1:0] win_o
);

  logic [MAX_KERNEL-1:0][MAX_KERNEL-1:0][SAMPLE_BITS-1:0] win_q;
  logic                                                   v_q;
  logic                                                   last_q;

  always_ff @(posedge clk_i) begin
    if (en_i && col_valid_i) begin
      win_q[0] <= col_i;
      for (int c = 1; c < MAX_KERNEL; c++) begin
        win_q[c] <= win_q[c-1];
      end
      last_q <= ctrl_i.last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= 1'b0;
    end else if (en_i) begin
      v_q <= col_valid_i && ctrl_i.emit;
    end
  end

  assign win_valid_o = v_q;
  assign win_last_o  = last_q;
  assign win_o       = win_q;

endmodule

`default_nettype wire

@@ src/mwmf_median.sv @@
// rank-based median over the masked window: compare, count, select
// depends on mwmf_pkg
`default_nettype none

module mwmf_median
  import mwmf_pkg::*;
#(
  parameter int unsigned MAX_KERNEL  = MAX_KERNEL_DEF,
  parameter int unsigned SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  wire logic                                              clk_i,
  input  wire logic                                              rst_ni,
  input  wire logic                                              en_i,
  input  wire logic                                              win_valid_i,
  input  wire logic                                              win_last_i,
  input  wire logic [MAX_KERNEL-1:0][MAX_KERNEL-1:0][SAMPLE_BITS-1:0] win_i,
  input  wire logic [KDIM_W-1:0]                                 kc_m1_i,
  input  wire logic [KDIM_W-1:0]                                 kr_m1_i,
  input  wire logic [MASK_W-1:0]                                 mask_i,
  output logic                                                   res_valid_o,
  output logic [SAMPLE_BITS-1:0]                                 res_value_o,
  output logic                                                   res_last_o,
  output logic                                                   res_empty_o
);

  localparam int unsigned N  = MAX_KERNEL * MAX_KERNEL;
  localparam int unsigned RW = $clog2(N + 1);

  logic [SAMPLE_BITS-1:0] vals [N];
  logic [N-1:0]           sel;
  logic [N-1:0]           prec [N];
  logic [SAMPLE_BITS-1:0] centre;
  logic [KDIM_W-1:0]      ca_c, ra_c;

  logic                   s3_v_q, s3_last_q;
  logic [N-1:0]           s3_sel_q;
  logic [N-1:0]           s3_prec_q [N];
  logic [RW-1:0]          s3_n_q;
  logic [SAMPLE_BITS-1:0] s3_vals_q [N];
  logic [SAMPLE_BITS-1:0] s3_centre_q;

  logic                   s4_v_q, s4_last_q, s4_empty_q;
  logic [N-1:0]           s4_sel_q;
  logic [RW-1:0]          s4_rank_q [N];
  logic [RW-1:0]          s4_half_q;
  logic [SAMPLE_BITS-1:0] s4_vals_q [N];
  logic [SAMPLE_BITS-1:0] s4_centre_q;
  logic [SAMPLE_BITS-1:0] med;

  assign ca_c = kc_m1_i - (kc_m1_i >> 1);
  assign ra_c = kr_m1_i - (kr_m1_i >> 1);

  always_comb begin
    logic [MASK_IDX_W-1:0] bidx;
    centre = '0;
    for (int ca = 0; ca < MAX_KERNEL; ca++) begin
      for (int ra = 0; ra < MAX_KERNEL; ra++) begin
        bidx = MASK_IDX_W'((MASK_IDX_W'(kr_m1_i) - MASK_IDX_W'(ra)) * MASK_IDX_W'(MASK_STRIDE)
               + MASK_IDX_W'(kc_m1_i) - MASK_IDX_W'(ca));
        vals[ca*MAX_KERNEL+ra] = win_i[ca][ra];
        sel[ca*MAX_KERNEL+ra]  = (KDIM_W'(ca) <= kc_m1_i) && (KDIM_W'(ra) <= kr_m1_i)
                                 && mask_i[bidx];
        if ((KDIM_W'(ca) == ca_c) && (KDIM_W'(ra) == ra_c)) begin
          centre = win_i[ca][ra];
        end
      end
    end
    for (int i = 0; i < N; i++) begin
      for (int j = 0; j < N; j++) begin
        prec[i][j] = (j != i) && sel[j] &&
                     (($signed(vals[j]) < $signed(vals[i])) ||
                      ((vals[j] == vals[i]) && (j < i)));
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s3_last_q   <= win_last_i;
      s3_sel_q    <= sel;
      s3_prec_q   <= prec;
      s3_n_q      <= RW'($countones(sel));
      s3_vals_q   <= vals;
      s3_centre_q <= centre;
      s4_last_q   <= s3_last_q;
      s4_sel_q    <= s3_sel_q;
      s4_half_q   <= s3_n_q >> 1;
      s4_empty_q  <= (s3_n_q == '0);
      s4_vals_q   <= s3_vals_q;
      s4_centre_q <= s3_centre_q;
      for (int i = 0; i < N; i++) begin
        s4_rank_q[i] <= RW'($countones(s3_prec_q[i]));
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_v_q <= 1'b0;
      s4_v_q <= 1'b0;
    end else if (en_i) begin
      s3_v_q <= win_valid_i;
      s4_v_q <= s3_v_q;
    end
  end

  always_comb begin
    med = '0;
    for (int i = 0; i < N; i++) begin
      if (s4_sel_q[i] && (s4_rank_q[i] == s4_half_q)) begin
        med = med | s4_vals_q[i];
      end
    end
  end

  assign res_valid_o = s4_v_q;
  assign res_value_o = s4_empty_q ? s4_centre_q : med;
  assign res_last_o  = s4_last_q;
  assign res_empty_o = s4_empty_q;

endmodule

`default_nettype wire

@@ src/masked_window_median_filter.sv @@
// masked window median filter, top level: counters, registers, output skid
// registered path: column store, window, median, output; one sample per cycle
// while not stalled, set by the single column memory read-modify-write per sample
// reset: counters cleared, registers to defaults, memory contents undefined
// depends on mwmf_pkg, mwmf_col_store, mwmf_window, mwmf_median
`default_nettype none

module masked_window_median_filter
  import mwmf_pkg::*;
#(
  parameter int unsigned MAX_KERNEL  = MAX_KERNEL_DEF,
  parameter int unsigned MAX_LINE    = MAX_LINE_DEF,
  parameter int unsigned SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_stall_o,
  input  wire logic signed [SAMPLE_BITS-1:0] sample_i,
  input  wire logic                          frame_start_i,
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output logic signed [SAMPLE_BITS-1:0]      median_value_o,
  output logic                               frame_last_o,
  output logic                               kernel_empty_o,
  input  wire logic                          cfg_valid_i,
  output logic                               cfg_ready_o,
  input  wire logic [CFG_IDX_W-1:0]          cfg_index_i,
  input  wire logic [MASK_W-1:0]             cfg_data_i
);

  localparam int unsigned CW = $clog2(MAX_LINE);

  logic [LINE_LEN_W-1:0]   line_length_q;
  logic [FRAME_ROWS_W-1:0] frame_rows_q;
  logic [KDIM_W-1:0]       kernel_cols_q, kernel_rows_q;
  logic [MASK_W-1:0]       kernel_mask_q;

  logic [CW-1:0]    col_q, col_cur;
  logic [ROW_W-1:0] row_q, row_cur;
  logic [CW-1:0]    len_m1;
  logic [ROW_W-1:0] rows_m1;
  logic [KDIM_W-1:0] kc_m1, kr_m1;
  logic             en, in_acc, col_end;
  pix_ctrl_t        ctrl, s1_ctrl;

  logic                                                   col_valid;
  logic [MAX_KERNEL-1:0][SAMPLE_BITS-1:0]                 col;
  logic                                                   win_valid, win_last;
  logic [MAX_KERNEL-1:0][MAX_KERNEL-1:0][SAMPLE_BITS-1:0] win;
  logic                                                   res_valid, res_last, res_empty;
  logic [SAMPLE_BITS-1:0]                                 res_value;

  logic                   out_v_q, skid_v_q;
  logic [SAMPLE_BITS-1:0] out_val_q, skid_val_q;
  logic                   out_last_q, out_empty_q, skid_last_q, skid_empty_q;
  logic                   push;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      line_length_q <= LINE_LEN_RST;
      frame_rows_q  <= FRAME_ROWS_RST;
      kernel_cols_q <= KDIM_RST;
      kernel_rows_q <= KDIM_RST;
      kernel_mask_q <= MASK_RST;
    end else if (cfg_valid_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_LINE_LENGTH: line_length_q <= cfg_data_i[LINE_LEN_W-1:0];
        CFG_FRAME_ROWS:  frame_rows_q  <= cfg_data_i[FRAME_ROWS_W-1:0];
        CFG_KERNEL_COLS: kernel_cols_q <= cfg_data_i[KDIM_W-1:0];
        CFG_KERNEL_ROWS: kernel_rows_q <= cfg_data_i[KDIM_W-1:0];
        CFG_KERNEL_MASK: kernel_mask_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // saturated register values, minus one
  always_comb begin
    if (line_length_q == '0) begin
      len_m1 = '0;
    end else if (32'(line_length_q) > 32'(MAX_LINE)) begin
      len_m1 = CW'(MAX_LINE - 1);
    end else begin
      len_m1 = CW'(line_length_q - 1'b1);
    end
    if (frame_rows_q == '0) begin
      rows_m1 = '0;
    end else if (32'(frame_rows_q) > 32'(MAX_ROWS)) begin
      rows_m1 = ROW_W'(MAX_ROWS - 1);
    end else begin
      rows_m1 = ROW_W'(frame_rows_q - 1'b1);
    end
    if (kernel_cols_q == '0) begin
      kc_m1 = '0;
    end else if (kernel_cols_q > KDIM_W'(MAX_KERNEL)) begin
      kc_m1 = KDIM_W'(MAX_KERNEL - 1);
    end else begin
      kc_m1 = kernel_cols_q - 1'b1;
    end
    if (kernel_rows_q == '0) begin
      kr_m1 = '0;
    end else if (kernel_rows_q > KDIM_W'(MAX_KERNEL)) begin
      kr_m1 = KDIM_W'(MAX_KERNEL - 1);
    end else begin
      kr_m1 = kernel_rows_q - 1'b1;
    end
  end

  assign en         = !skid_v_q;
  assign in_stall_o = skid_v_q;
  assign in_acc     = in_valid_i && en;

  assign col_cur   = frame_start_i ? '0 : col_q;
  assign row_cur   = frame_start_i ? '0 : row_q;
  assign col_end   = col_cur >= len_m1;
  assign ctrl.emit = (row_cur >= ROW_W'(kr_m1)) && (col_cur >= CW'(kc_m1));
  assign ctrl.last = col_end && (row_cur >= rows_m1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else if (in_acc) begin
      if (col_end) begin
        col_q <= '0;
        row_q <= (row_cur >= rows_m1) ? '0 : row_cur + 1'b1;
      end else begin
        col_q <= col_cur + 1'b1;
        row_q <= row_cur;
      end
    end
  end

  mwmf_col_store #(
    .MAX_KERNEL (MAX_KERNEL),
    .MAX_LINE   (MAX_LINE),
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_col_store (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (en),
    .rd_i       (in_acc),
    .rd_addr_i  (col_cur),
    .sample_i   (sample_i),
    .ctrl_i     (ctrl),
    .col_valid_o(col_valid),
    .col_o      (col),
    .ctrl_o     (s1_ctrl)
  );

  mwmf_window #(
    .MAX_KERNEL (MAX_KERNEL),
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_window (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (en),
    .col_valid_i(col_valid),
    .col_i      (col),
    .ctrl_i     (s1_ctrl),
    .win_valid_o(win_valid),
    .win_last_o (win_last),
    .win_o      (win)
  );

  mwmf_median #(
    .MAX_KERNEL (MAX_KERNEL),
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_median (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (en),
    .win_valid_i(win_valid),
    .win_last_i (win_last),
    .win_i      (win),
    .kc_m1_i    (kc_m1),
    .kr_m1_i    (kr_m1),
    .mask_i     (kernel_mask_q),
    .res_valid_o(res_valid),
    .res_value_o(res_value),
    .res_last_o (res_last),
    .res_empty_o(res_empty)
  );

  // output register plus skid entry
  assign push = en && res_valid;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q  <= 1'b0;
      skid_v_q <= 1'b0;
    end else if (out_v_q && !out_stall_i) begin
      if (skid_v_q) begin
        out_val_q   <= skid_val_q;
        out_last_q  <= skid_last_q;
        out_empty_q <= skid_empty_q;
        skid_v_q    <= 1'b0;
      end else if (push) begin
        out_val_q   <= res_value;
        out_last_q  <= res_last;
        out_empty_q <= res_empty;
      end else begin
        out_v_q <= 1'b0;
      end
    end else if (!out_v_q) begin
      if (push) begin
        out_v_q     <= 1'b1;
        out_val_q   <= res_value;
        out_last_q  <= res_last;
        out_empty_q <= res_empty;
      end
    end else if (push) begin
      skid_v_q     <= 1'b1;
      skid_val_q   <= res_value;
      skid_last_q  <= res_last;
      skid_empty_q <= res_empty;
    end
  end

  assign out_valid_o    = out_v_q;
  assign median_value_o = out_val_q;
  assign frame_last_o   = out_last_q;
  assign kernel_empty_o = out_empty_q;

endmodule

`default_nettype wire
